FILE: hw/rtl/dqu_pkg.sv
// ----------------------------------------------------------------------------
// dqu_pkg
// Shared types, codes and defaults of the double-ended queue unit.
// ----------------------------------------------------------------------------
package dqu_pkg;

  localparam int DefCapacity  = 16;
  localparam int DefDataWidth = 32;

  localparam int CmdW   = 3;
  localparam int WordW  = 32;
  localparam int CountW = 5;
  localparam int StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic signed [WordW-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] front_value;
    logic signed [WordW-1:0] back_value;
    logic [CountW-1:0]       count;
    logic [StatW-1:0]        status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic rd;
    logic load;
  } ctrl_t;

endpackage

FILE: hw/rtl/dqu_ram.sv
// ----------------------------------------------------------------------------
// dqu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/dqu_ctrl.sv
// ----------------------------------------------------------------------------
// dqu_ctrl
// Command sequencer: accept, ring read, result load; owns the output valid.
// ----------------------------------------------------------------------------
module dqu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dqu_pkg::ctrl_t ctrl_o
);

  import dqu_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.exec = in_valid_i;
      end
      S_READ: ctrl_o.rd = 1'b1;
      S_LOAD: ctrl_o.load = slot_free;
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/dqu_datapath.sv
// ----------------------------------------------------------------------------
// dqu_datapath
// Ring pointers, occupancy, slot RAM copies and the result register.
// ----------------------------------------------------------------------------
module dqu_datapath #(
  parameter int CAPACITY   = dqu_pkg::DefCapacity,
  parameter int DATA_WIDTH = dqu_pkg::DefDataWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dqu_pkg::ctrl_t ctrl_i,
  input  dqu_pkg::in_t   in_data_i,
  output dqu_pkg::out_t  out_data_o
);

  import dqu_pkg::*;

  localparam int PtrW = $clog2(CAPACITY);
  localparam int OccW = $clog2(CAPACITY + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(CAPACITY - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(CAPACITY);

  function automatic logic [PtrW-1:0] ring_inc(input logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ring_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  logic [PtrW-1:0]       front_q, front_d;
  logic [PtrW-1:0]       back_q, back_d;
  logic [OccW-1:0]       occ_q, occ_d;
  logic [StatW-1:0]      status_q, status_d;
  out_t                  out_q, out_d;
  logic                  full, empty;
  logic                  we;
  logic [PtrW-1:0]       waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic signed [DATA_WIDTH-1:0] front_rd, back_rd;

  assign full  = (occ_q == FullOcc);
  assign empty = (occ_q == '0);
  assign wdata = DATA_WIDTH'(in_data_i.push_value);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    occ_d    = occ_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = back_q;
    if (ctrl_i.exec) begin
      status_d = ST_DONE;
      unique case (in_data_i.command)
        CMD_PUSH_BACK: begin
          if (full) begin
            status_d = ST_PUSH_FULL;
          end else begin
            we     = 1'b1;
            waddr  = back_q;
            back_d = ring_inc(back_q);
            occ_d  = occ_q + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_PUSH_FULL;
          end else begin
            we      = 1'b1;
            waddr   = ring_dec(front_q);
            front_d = ring_dec(front_q);
            occ_d   = occ_q + 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_d = ST_POP_EMPTY;
          end else begin
            back_d = ring_dec(back_q);
            occ_d  = occ_q - 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_d = ST_POP_EMPTY;
          end else begin
            front_d = ring_inc(front_q);
            occ_d   = occ_q - 1'b1;
          end
        end
        default: status_d = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      occ_q   <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  // two copies so front and back are read in the same cycle
  dqu_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram_front (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd),
    .raddr_i(front_q),
    .rdata_o(front_rd)
  );

  dqu_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram_back (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd),
    .raddr_i(ring_dec(back_q)),
    .rdata_o(back_rd)
  );

  always_comb begin
    out_d.front_value = empty ? '1 : WordW'(front_rd);
    out_d.back_value  = empty ? '1 : WordW'(back_rd);
    out_d.count       = CountW'(occ_q);
    out_d.status      = status_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
// The unit takes one command word (push back, push front, pop back, pop front,
// peek) and returns one result word with the front and back words, the count
// after the command and a status. It takes one command at a time: the accept
// cycle updates the ring pointers and writes the slot RAM, the next cycle
// reads the front and back slots from two RAM copies, and the load state
// then loads the result register. The load waits while the result register
// still holds a word that has not been taken; the next command is accepted
// while a finished result is waiting. Empty queue reads -1 on both ends.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed data words.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int CAPACITY   = dqu_pkg::DefCapacity,
  parameter int DATA_WIDTH = dqu_pkg::DefDataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dqu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dqu_pkg::out_t out_data_o
);

  import dqu_pkg::*;

  ctrl_t ctrl;

  dqu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ctrl_o     (ctrl)
  );

  dqu_datapath #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

FILE: hw/rtl/dqu_checker.sv
// ----------------------------------------------------------------------------
// dqu_checker
// Port-level checks of the double-ended queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module dqu_checker #(
  parameter int CAPACITY = dqu_pkg::DefCapacity
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input dqu_pkg::out_t out_data_o
);

  import dqu_pkg::*;

  localparam bit CountExact = (CAPACITY < 32);
  localparam logic [CountW-1:0] FullCount = CountW'(CAPACITY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && CountExact |-> out_data_o.count <= FullCount)
    else $error("count above capacity");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && CountExact && out_data_o.count == '0 |->
      out_data_o.front_value == '1 && out_data_o.back_value == '1)
    else $error("empty queue must read -1 at both ends");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && CountExact && out_data_o.status == ST_PUSH_FULL |->
      out_data_o.count == FullCount)
    else $error("push dropped while not full");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && CountExact && out_data_o.status == ST_POP_EMPTY |->
      out_data_o.count == '0)
    else $error("pop flagged while not empty");

endmodule

bind double_ended_queue_unit dqu_checker #(
  .CAPACITY(CAPACITY)
) u_dqu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

FILE: tb/sv/double_ended_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Self-checking bench for the double-ended queue unit. A ring model of the
// deque predicts the front, back, count and status of every command word.
// Each reply is compared with the oldest prediction while either handshake
// may idle at random, and the queue is driven through empty, full and wrap.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqu_pkg::*;

  localparam int  Depth      = DefCapacity;
  localparam int  MaxIdle    = 17;
  localparam int  RandItems  = 1250;
  localparam int  CycleLimit = 400000;
  localparam logic signed [WordW-1:0] EmptyWord = -1;

  // unused command codes, handled as peek
  localparam logic [CmdW-1:0] CmdSpare5 = 3'd5;
  localparam logic [CmdW-1:0] CmdSpare6 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  double_ended_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // deque model state
  logic signed [WordW-1:0] ring_mem [Depth];
  int   head_idx;
  int   tail_idx;
  int   fill;

  out_t reply_q[$];
  int   errors        = 0;
  int   cycle_cnt     = 0;
  bit   tx_idle       = 1'b0;
  bit   rx_idle       = 1'b0;
  int   rx_hold_cycles = 0;

  function automatic out_t deque_apply(in_t w);
    out_t r;
    r.status = ST_DONE;
    case (w.command) inside
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (fill >= Depth) begin
          r.status = ST_PUSH_FULL;
        end else if (w.command == CMD_PUSH_BACK) begin
          ring_mem[tail_idx] = w.push_value;
          tail_idx = (tail_idx + 1) % Depth;
          fill++;
        end else begin
          head_idx = (head_idx + Depth - 1) % Depth;
          ring_mem[head_idx] = w.push_value;
          fill++;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (fill == 0) begin
          r.status = ST_POP_EMPTY;
        end else if (w.command == CMD_POP_BACK) begin
          tail_idx = (tail_idx + Depth - 1) % Depth;
          fill--;
        end else begin
          head_idx = (head_idx + 1) % Depth;
          fill--;
        end
      end
      default: ;
    endcase
    if (fill == 0) begin
      r.front_value = EmptyWord;
      r.back_value  = EmptyWord;
    end else begin
      r.front_value = ring_mem[head_idx];
      r.back_value  = ring_mem[(tail_idx + Depth - 1) % Depth];
    end
    r.count = fill[CountW-1:0];
    return r;
  endfunction

  task automatic send_word(logic [CmdW-1:0] cmd, logic signed [WordW-1:0] value);
    int   gap;
    in_t  w;
    gap = tx_idle ? $urandom_range(0, MaxIdle) : 0;
    w.command    = cmd;
    w.push_value = value;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    reply_q.push_back(deque_apply(w));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [WordW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // push-heavy or pop-heavy mix; a few peeks and unused codes
  function automatic logic [CmdW-1:0] rand_cmd(bit grow);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return CmdW'($urandom_range(CMD_PEEK, CmdSpare7));
    if (roll < 74) return grow ? CmdW'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT))
                               : CmdW'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT));
    return grow ? CmdW'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT))
                : CmdW'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT));
  endfunction

  task automatic test_empty();
    send_word(CMD_PEEK, rand_word());
    send_word(CMD_POP_BACK, rand_word());
    send_word(CMD_POP_FRONT, rand_word());
    send_word(CmdSpare7, rand_word());
    drain();
  endtask

  task automatic test_extremes();
    send_word(CMD_PUSH_BACK, 32'sh8000_0000);
    send_word(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_word(CmdSpare5, 32'sd0);
    send_word(CMD_POP_BACK, -32'sd1);
    send_word(CMD_POP_FRONT, 32'sd0);
    drain();
  endtask

  task automatic test_full();
    for (int i = 0; i < Depth; i++) begin
      send_word(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rand_word());
    end
    send_word(CMD_PUSH_BACK, 32'sh7fff_ffff);
    send_word(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_word(CmdSpare6, -32'sd1);
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_word(rand_cmd(i < 25), rand_word());
    end
    drain();
  endtask

  task automatic test_random();
    int  run_left;
    bit  grow;
    run_left = 0;
    grow     = 1'b1;
    for (int i = 0; i < RandItems; i++) begin
      if (i % 250 == 0) begin
        drain();
        tx_idle = (i / 250) % 2 == 0;
        rx_idle = (i / 250) < 3;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        grow     = $urandom_range(0, 1);
      end
      run_left--;
      send_word(rand_cmd(grow), rand_word());
    end
    drain();
  endtask

  initial begin : rx_proc
    int   stall;
    out_t got;
    out_t want;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, MaxIdle) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = out_data_o;
      if (reply_q.size() == 0) begin
        $display("%0t: word with none pending: %p", $time, got);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (got.front_value !== want.front_value) begin
          $display("%0t: front_value exp %0d got %0d", $time, want.front_value,
                   got.front_value);
          errors++;
        end
        if (got.back_value !== want.back_value) begin
          $display("%0t: back_value exp %0d got %0d", $time, want.back_value,
                   got.back_value);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    head_idx = 0;
    tail_idx = 0;
    fill     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_empty();
    test_extremes();
    test_full();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dqu_pkg.sv
hw/rtl/dqu_ram.sv
hw/rtl/dqu_ctrl.sv
hw/rtl/dqu_datapath.sv
hw/rtl/double_ended_queue_unit.sv
hw/rtl/dqu_checker.sv
tb/sv/double_ended_queue_unit_tb.sv
